### design/mhpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
package mhpq_pkg;

  // Field widths of the stream payloads and the configuration register.
  localparam int KEY_W       = 32;
  localparam int FUNC_W      = 2;
  localparam int STAT_W      = 2;
  localparam int CNT_OUT_W   = 7;
  localparam int CAP_W       = 7;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (STAT_W + 1 + KEY_W + CNT_OUT_W);

  // Capacity limit after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Operation carried in the input item's tuser.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_FIND   = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  // Status reported with every result item.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_DUP   = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_DEL_TOP,
    ST_DEL_LAST,
    ST_DEL_GRAB,
    ST_DN_L,
    ST_DN_R,
    ST_DN_CMP,
    ST_RESP
  } state_t;

endpackage

### design/mhpq_mem.sv
// Key store of the heap: one write port and one registered read port.
module mhpq_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [AW-1:0]                       rd_addr,
  output logic signed [mhpq_pkg::KEY_W-1:0]   rd_data,
  input  logic                                wr_en,
  input  logic [AW-1:0]                       wr_addr,
  input  logic signed [mhpq_pkg::KEY_W-1:0]   wr_data
);

  logic signed [mhpq_pkg::KEY_W-1:0] mem_r [DEPTH];
  logic signed [mhpq_pkg::KEY_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port: data appears in the cycle after the read and holds when no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/max_heap_priority_queue.sv
// Top level of the binary max-heap priority queue with its operation sequencer.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------------
//  in      | slave     | in_tvalid / in_tready | tuser: func; tdata: key_value
//  out     | master    | out_tvalid/out_tready | tdata: status, found, max_value, count
//  cfg     | slave     | cfg_valid / cfg_ready | cfg_data: capacity_limit
//
// One item is in work at a time; the memory's single read port sets the pace.
// Insert runs a full scan for duplicates, then sift-up with a parent read and a compare
// per level; find runs the scan alone; delete-max sifts down with two child reads and a
// compare per level; clear empties the heap without touching the store.
// Reset is synchronous and active low; it empties the heap and sets the limit to 64.
// A finished result waits in the output register while the next item is accepted.
module max_heap_priority_queue #(
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input items.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [mhpq_pkg::IN_TDATA_W-1:0]      in_tdata,   // [31:0] key_value
  input  logic [mhpq_pkg::FUNC_W-1:0]          in_tuser,   // [1:0] func
  // Result items.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [1:0] status, [2] found, [34:3] max_value, [41:35] count, [47:42] zero
  output logic [mhpq_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // Capacity limit register.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mhpq_pkg::CAP_W-1:0]           cfg_data
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int XW   = AW + 2;
  localparam int CMPW = (CW > mhpq_pkg::CAP_W) ? CW : mhpq_pkg::CAP_W;

  // Control and payload registers.
  mhpq_pkg::state_t                  state_r, state_nxt;
  mhpq_pkg::func_t                   op_r, op_nxt;
  logic signed [mhpq_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [CW-1:0]                     count_r, count_nxt;
  logic [mhpq_pkg::CAP_W-1:0]        cap_r;
  logic [AW-1:0]                     pos_r, pos_nxt;
  logic [CW-1:0]                     scan_idx_r, scan_idx_nxt;
  logic                              cmp_v_r, cmp_v_nxt;
  logic signed [mhpq_pkg::KEY_W-1:0] top_r, top_nxt;
  logic signed [mhpq_pkg::KEY_W-1:0] last_r, last_nxt;
  logic signed [mhpq_pkg::KEY_W-1:0] lchild_r, lchild_nxt;
  mhpq_pkg::status_t                 res_status_r, res_status_nxt;
  logic                              res_found_r, res_found_nxt;
  logic signed [mhpq_pkg::KEY_W-1:0] res_max_r, res_max_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [mhpq_pkg::OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;

  // Memory port signals.
  logic                              mem_re;
  logic [AW-1:0]                     mem_raddr;
  logic signed [mhpq_pkg::KEY_W-1:0] mem_rdata;
  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  logic signed [mhpq_pkg::KEY_W-1:0] mem_wdata;

  // Decisions shared by the next-state and datapath logic.
  logic              in_acc;
  logic              is_full;
  logic              scan_hit;
  logic              scan_end;
  logic [AW-1:0]     parent;
  logic              up_move;
  logic [XW-1:0]     child;
  logic [XW-1:0]     right;
  logic [XW-1:0]     count_x;
  logic              child_ok;
  logic              right_ok;
  logic              pick_right;
  logic signed [mhpq_pkg::KEY_W-1:0] big;
  logic              dn_move;
  logic              out_free;
  logic [CMPW-1:0]   count_cmp;
  logic [CMPW-1:0]   cap_cmp;

  mhpq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata)
  );

  assign in_tready  = (state_r == mhpq_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  // Fullness against min(limit, DEPTH).
  assign count_cmp = CMPW'(count_r);
  assign cap_cmp   = CMPW'(cap_r);
  assign is_full   = (count_cmp >= cap_cmp) || (count_r == CW'(DEPTH));

  // Linear scan compares the key read in the previous cycle.
  assign scan_hit = cmp_v_r && (mem_rdata == key_r);
  assign scan_end = !cmp_v_r && (scan_idx_r >= count_r);

  // Sift-up: parent slot and whether the parent moves down.
  assign parent  = (pos_r - AW'(1)) >> 1;
  assign up_move = mem_rdata < key_r;

  // Sift-down: children of the current slot and the larger of them.
  assign child      = {1'b0, pos_r, 1'b1};
  assign right      = child + XW'(1);
  assign count_x    = XW'(count_r);
  assign child_ok   = child < count_x;
  assign right_ok   = right < count_x;
  assign pick_right = right_ok && (mem_rdata > lchild_r);
  assign big        = pick_right ? mem_rdata : lchild_r;
  assign dn_move    = last_r < big;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mhpq_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (mhpq_pkg::func_t'(in_tuser))
            mhpq_pkg::FUNC_INSERT: state_nxt = is_full ? mhpq_pkg::ST_RESP : mhpq_pkg::ST_SCAN;
            mhpq_pkg::FUNC_DELETE: begin
              state_nxt = (count_r == '0) ? mhpq_pkg::ST_RESP : mhpq_pkg::ST_DEL_TOP;
            end
            mhpq_pkg::FUNC_FIND:   state_nxt = mhpq_pkg::ST_SCAN;
            default:               state_nxt = mhpq_pkg::ST_RESP;
          endcase
        end
      end
      mhpq_pkg::ST_SCAN: begin
        if (scan_hit) begin
          state_nxt = mhpq_pkg::ST_RESP;
        end else if (scan_end) begin
          state_nxt = (op_r == mhpq_pkg::FUNC_INSERT) ? mhpq_pkg::ST_UP_CHK : mhpq_pkg::ST_RESP;
        end
      end
      mhpq_pkg::ST_UP_CHK: begin
        state_nxt = (pos_r == '0) ? mhpq_pkg::ST_RESP : mhpq_pkg::ST_UP_CMP;
      end
      mhpq_pkg::ST_UP_CMP: begin
        state_nxt = up_move ? mhpq_pkg::ST_UP_CHK : mhpq_pkg::ST_RESP;
      end
      mhpq_pkg::ST_DEL_TOP:  state_nxt = mhpq_pkg::ST_DEL_LAST;
      mhpq_pkg::ST_DEL_LAST: state_nxt = mhpq_pkg::ST_DEL_GRAB;
      mhpq_pkg::ST_DEL_GRAB: state_nxt = mhpq_pkg::ST_DN_L;
      mhpq_pkg::ST_DN_L: begin
        state_nxt = child_ok ? mhpq_pkg::ST_DN_R : mhpq_pkg::ST_RESP;
      end
      mhpq_pkg::ST_DN_R:   state_nxt = mhpq_pkg::ST_DN_CMP;
      mhpq_pkg::ST_DN_CMP: state_nxt = dn_move ? mhpq_pkg::ST_DN_L : mhpq_pkg::ST_RESP;
      mhpq_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = mhpq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mhpq_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory accesses and result fields.
  always_comb begin
    op_nxt         = op_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_v_nxt      = cmp_v_r;
    top_nxt        = top_r;
    last_nxt       = last_r;
    lchild_nxt     = lchild_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_max_nxt    = res_max_r;
    out_valid_nxt  = out_tready ? 1'b0 : out_valid_r;
    out_data_nxt   = out_data_r;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    mem_we         = 1'b0;
    mem_waddr      = pos_r;
    mem_wdata      = key_r;

    unique case (state_r)
      mhpq_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_nxt         = mhpq_pkg::func_t'(in_tuser);
          key_nxt        = $signed(in_tdata);
          scan_idx_nxt   = '0;
          cmp_v_nxt      = 1'b0;
          res_status_nxt = mhpq_pkg::STAT_OK;
          res_found_nxt  = 1'b0;
          res_max_nxt    = '0;
          case (mhpq_pkg::func_t'(in_tuser))
            mhpq_pkg::FUNC_INSERT: begin
              if (is_full) begin
                res_status_nxt = mhpq_pkg::STAT_FULL;
              end
            end
            mhpq_pkg::FUNC_DELETE: begin
              if (count_r == '0) begin
                res_status_nxt = mhpq_pkg::STAT_EMPTY;
              end
            end
            mhpq_pkg::FUNC_CLEAR: count_nxt = '0;
            default: ;
          endcase
        end
      end
      // One read per cycle over the held keys; each compare uses the key read in the cycle before.
      mhpq_pkg::ST_SCAN: begin
        if (scan_idx_r < count_r) begin
          mem_re       = 1'b1;
          mem_raddr    = scan_idx_r[AW-1:0];
          scan_idx_nxt = scan_idx_r + CW'(1);
          cmp_v_nxt    = 1'b1;
        end else begin
          cmp_v_nxt = 1'b0;
        end
        if (scan_hit) begin
          if (op_r == mhpq_pkg::FUNC_INSERT) begin
            res_status_nxt = mhpq_pkg::STAT_DUP;
          end else begin
            res_found_nxt = 1'b1;
          end
        end else if (scan_end) begin
          pos_nxt = count_r[AW-1:0];
        end
      end
      // Sift-up: read the parent, or place the key at the root.
      mhpq_pkg::ST_UP_CHK: begin
        if (pos_r == '0) begin
          mem_we    = 1'b1;
          count_nxt = count_r + CW'(1);
        end else begin
          mem_re    = 1'b1;
          mem_raddr = parent;
        end
      end
      mhpq_pkg::ST_UP_CMP: begin
        mem_we = 1'b1;
        if (up_move) begin
          mem_wdata = mem_rdata;
          pos_nxt   = parent;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      // Delete-max: fetch the root, then the last key.
      mhpq_pkg::ST_DEL_TOP: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        count_nxt = count_r - CW'(1);
      end
      mhpq_pkg::ST_DEL_LAST: begin
        top_nxt   = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = count_r[AW-1:0];
      end
      mhpq_pkg::ST_DEL_GRAB: begin
        last_nxt = mem_rdata;
        pos_nxt  = '0;
      end
      // Sift-down: read left child, then right child, then compare and move.
      mhpq_pkg::ST_DN_L: begin
        if (child_ok) begin
          mem_re    = 1'b1;
          mem_raddr = child[AW-1:0];
        end else begin
          mem_we      = 1'b1;
          mem_wdata   = last_r;
          res_max_nxt = top_r;
        end
      end
      mhpq_pkg::ST_DN_R: begin
        lchild_nxt = mem_rdata;
        if (right_ok) begin
          mem_re    = 1'b1;
          mem_raddr = right[AW-1:0];
        end
      end
      mhpq_pkg::ST_DN_CMP: begin
        mem_we = 1'b1;
        if (dn_move) begin
          mem_wdata = big;
          pos_nxt   = pick_right ? right[AW-1:0] : child[AW-1:0];
        end else begin
          mem_wdata   = last_r;
          res_max_nxt = top_r;
        end
      end
      // Hand the result to the output register once it is free.
      mhpq_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{mhpq_pkg::OUT_PAD_W{1'b0}},
                           mhpq_pkg::CNT_OUT_W'(CMPW'(count_r)),
                           res_max_r, res_found_r, res_status_r};
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mhpq_pkg::ST_IDLE;
      count_r     <= '0;
      cap_r       <= mhpq_pkg::CAP_RESET;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    pos_r        <= pos_nxt;
    scan_idx_r   <= scan_idx_nxt;
    top_r        <= top_nxt;
    last_r       <= last_nxt;
    lchild_r     <= lchild_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_max_r    <= res_max_nxt;
    out_data_r   <= out_data_nxt;
  end

  // The heap never holds more keys than the store has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("heap count exceeds store depth");

  // The sequencer never reads and writes the store in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_re && mem_we))
    else $error("store read and write in the same cycle");

  // A new result appears only when the sequencer hands one over.
  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == mhpq_pkg::ST_RESP))
    else $error("result raised outside the response state");

  // A waiting result is never overwritten before it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(out_data_r))
    else $error("pending result changed while stalled");

endmodule
